/* sv/drp_pkg.sv */
package drp_pkg;

    localparam int DISP_W     = 16;
    localparam int COORD_W    = 32;
    localparam int CNT_W      = 12;
    localparam int SIZE_W     = 13;
    localparam int BASE_W     = 24;
    localparam int PARM_W     = 16;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int DIVR_W     = DISP_W - 1;
    localparam int Q_W        = BASE_W + 12;
    localparam int HALF_W     = Q_W / 2;
    localparam int OPD_W      = 18;
    localparam int PROD_W     = OPD_W + HALF_W + 1;
    localparam int ACC_W      = 56;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_BASELINE     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FOCAL_LENGTH = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_COL   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_ROW   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

    typedef struct packed {
        logic                    pos;
        logic [DIVR_W-1:0]       disp;
        logic signed [OPD_W-1:0] dx;
        logic signed [OPD_W-1:0] dy;
        logic                    frame_end;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } back_state_t;

endpackage

/* sv/drp_front.sv */
module drp_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [drp_pkg::DISP_W-1:0] s_disparity,
    input  logic [drp_pkg::SIZE_W-1:0]        image_width,
    input  logic [drp_pkg::SIZE_W-1:0]        image_height,
    input  logic [drp_pkg::PARM_W-1:0]        center_col,
    input  logic [drp_pkg::PARM_W-1:0]        center_row,
    input  drp_pkg::q_status_t                q_status,
    output logic                              push,
    output drp_pkg::item_t                    item
);
    localparam logic [drp_pkg::SIZE_W-1:0] MAXW = drp_pkg::SIZE_W'(drp_pkg::MAX_WIDTH);
    localparam logic [drp_pkg::SIZE_W-1:0] MAXH = drp_pkg::SIZE_W'(drp_pkg::MAX_HEIGHT);
    localparam logic [drp_pkg::SIZE_W-1:0] ONE  = drp_pkg::SIZE_W'(1);

    logic [drp_pkg::CNT_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [drp_pkg::SIZE_W-1:0] w, h;
    logic last_col, last_row;

    always_comb begin
        if (image_width == '0) begin
            w = ONE;
        end else if (image_width > MAXW) begin
            w = MAXW;
        end else begin
            w = image_width;
        end
        if (image_height == '0) begin
            h = ONE;
        end else if (image_height > MAXH) begin
            h = MAXH;
        end else begin
            h = image_height;
        end
        last_col = ({1'b0, col_reg} + ONE) >= w;
        last_row = ({1'b0, row_reg} + ONE) >= h;
        col_next = col_reg;
        row_next = row_reg;
        if (push) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;

    assign item.pos       = !s_disparity[drp_pkg::DISP_W-1] && (s_disparity != '0);
    assign item.disp      = s_disparity[drp_pkg::DIVR_W-1:0];
    assign item.dx        = $signed({2'b00, col_reg, 4'b0000}) - $signed({2'b00, center_col});
    assign item.dy        = $signed({2'b00, row_reg, 4'b0000}) - $signed({2'b00, center_row});
    assign item.frame_end = last_col && last_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end
endmodule

/* sv/drp_queue.sv */
module drp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  drp_pkg::item_t     wr_item,
    input  logic               pop,
    output drp_pkg::item_t     rd_item,
    output drp_pkg::q_status_t status
);
    drp_pkg::item_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign status.full  = count_reg == 2'd2;
    assign status.empty = count_reg == 2'd0;
    assign rd_item      = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end
endmodule

/* sv/drp_div.sv */
module drp_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [drp_pkg::Q_W-1:0]     dividend,
    input  logic [drp_pkg::DIVR_W-1:0]  divisor,
    output logic                        done,
    output logic [drp_pkg::Q_W-1:0]     quotient
);
    localparam int CW = $clog2(drp_pkg::Q_W + 1);

    logic [drp_pkg::Q_W-1:0]    quo_reg;
    logic [drp_pkg::DIVR_W-1:0] rem_reg, dvs_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg, done_reg;
    logic [drp_pkg::DIVR_W:0]   rem_sh, rem_sub;
    logic                       ge;

    assign rem_sh   = {rem_reg, quo_reg[drp_pkg::Q_W-1]};
    assign ge       = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub  = rem_sh - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[drp_pkg::Q_W-2:0], ge};
            rem_reg <= ge ? rem_sub[drp_pkg::DIVR_W-1:0] : rem_sh[drp_pkg::DIVR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(drp_pkg::Q_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

/* sv/drp_back.sv */
module drp_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  drp_pkg::q_status_t                 q_status,
    input  drp_pkg::item_t                     head,
    output logic                               pop,
    input  logic [drp_pkg::BASE_W-1:0]         baseline,
    input  logic [drp_pkg::PARM_W-1:0]         focal_length,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [drp_pkg::COORD_W-1:0] m_point_x,
    output logic signed [drp_pkg::COORD_W-1:0] m_point_y,
    output logic signed [drp_pkg::COORD_W-1:0] m_point_z,
    output logic                               m_point_valid,
    output logic                               m_saturated,
    output logic                               m_frame_end
);
    localparam int AW = drp_pkg::ACC_W;
    localparam int RW = AW - 8;

    drp_pkg::back_state_t state_reg, state_next;
    drp_pkg::item_t       item_reg;
    logic [drp_pkg::Q_W-1:0]        q_reg, div_q;
    logic                           div_done, div_start;
    logic [3:0]                     step_reg;
    logic signed [drp_pkg::PROD_W-1:0] prod_reg;
    logic signed [AW-1:0]           acc_reg;
    logic [drp_pkg::COORD_W-1:0]    res_reg [3];
    logic [2:0]                     sat_reg;
    logic signed [drp_pkg::OPD_W-1:0]  opd;
    logic [drp_pkg::HALF_W-1:0]     qhalf;
    logic signed [drp_pkg::PROD_W-1:0] prod;
    logic                           acc_neg, ovf;
    logic [AW-1:0]                  acc_mag;
    logic [RW-1:0]                  rnd;
    logic [drp_pkg::COORD_W-1:0]    rval;
    logic                           load_out, mul_end;
    logic                           m_valid_reg;

    drp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({baseline, 12'b0}),
        .divisor  (head.disp),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        case (step_reg[3:2])
            2'd0:    opd = item_reg.dx;
            2'd1:    opd = item_reg.dy;
            default: opd = $signed({2'b00, focal_length});
        endcase
        qhalf   = step_reg[0] ? q_reg[drp_pkg::Q_W-1:drp_pkg::HALF_W]
                              : q_reg[drp_pkg::HALF_W-1:0];
        prod    = opd * $signed({1'b0, qhalf});
        acc_neg = acc_reg[AW-1];
        acc_mag = acc_neg ? -acc_reg : acc_reg;
        rnd     = RW'((acc_mag + AW'(128)) >> 8);
        ovf     = acc_neg ? (rnd > RW'(64'h80000000)) : (rnd > RW'(64'h7FFFFFFF));
        if (ovf) begin
            rval = acc_neg ? 32'h80000000 : 32'h7FFFFFFF;
        end else begin
            rval = acc_neg ? -rnd[drp_pkg::COORD_W-1:0] : rnd[drp_pkg::COORD_W-1:0];
        end
    end

    assign mul_end  = step_reg == 4'd11;
    assign load_out = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            drp_pkg::ST_IDLE: begin
                if (!q_status.empty) begin
                    pop        = 1'b1;
                    div_start  = head.pos;
                    state_next = head.pos ? drp_pkg::ST_DIV : drp_pkg::ST_OUT;
                end
            end
            drp_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = drp_pkg::ST_MUL;
                end
            end
            drp_pkg::ST_MUL: begin
                if (mul_end) begin
                    state_next = drp_pkg::ST_OUT;
                end
            end
            drp_pkg::ST_OUT: begin
                if (load_out) begin
                    state_next = drp_pkg::ST_IDLE;
                end
            end
            default: state_next = drp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= drp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg <= head;
            sat_reg  <= '0;
        end
        if (state_reg == drp_pkg::ST_DIV && div_done) begin
            q_reg    <= div_q;
            step_reg <= '0;
        end
        if (state_reg == drp_pkg::ST_MUL) begin
            step_reg <= step_reg + 4'd1;
            case (step_reg[1:0])
                2'd0: begin
                    prod_reg <= prod;
                end
                2'd1: begin
                    acc_reg  <= AW'(prod_reg);
                    prod_reg <= prod;
                end
                2'd2: begin
                    acc_reg <= acc_reg + (AW'(prod_reg) <<< drp_pkg::HALF_W);
                end
                default: begin
                    res_reg[step_reg[3:2]] <= rval;
                    sat_reg[step_reg[3:2]] <= ovf;
                end
            endcase
        end
        if (state_reg == drp_pkg::ST_OUT && load_out) begin
            m_point_x     <= item_reg.pos ? res_reg[0] : '0;
            m_point_y     <= item_reg.pos ? res_reg[1] : '0;
            m_point_z     <= item_reg.pos ? res_reg[2] : '0;
            m_point_valid <= item_reg.pos;
            m_saturated   <= item_reg.pos && (sat_reg != '0);
            m_frame_end   <= item_reg.frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == drp_pkg::ST_OUT && load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
endmodule

/* sv/disparity_to_point_reprojection_top.sv */
// Disparity-to-3D point reprojection.
// Input channel s_*: one signed Q8.8 disparity pixel per item, raster order.
// Output channel m_*: one point per pixel (Q20.12 x/y/z, point_valid,
// saturated, frame_end), in input order.
// cfg_wr_en/cfg_addr/cfg_wdata write the six camera and image registers;
// write only while the block is idle. Unknown addresses are ignored.
// A front stage tracks column/row and queues items in a two-entry queue;
// the back end runs a radix-2 divider for baseline/disparity followed by
// a shared 18x18 multiplier for the three coordinates. The back end takes
// one pixel at a time: a positive disparity goes through the divider and
// multiplier sequence, an invalid one skips both, and meanwhile the queue
// holds up to two further pixels.
// Reset (aresetn low, synchronous) clears counters, queue and output valid
// and restores register defaults. A stalled receiver holds the result in
// the output register; the queue keeps accepting until it fills.
module disparity_to_point_reprojection_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [drp_pkg::DISP_W-1:0]   s_disparity,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [drp_pkg::COORD_W-1:0]  m_point_x,
    output logic signed [drp_pkg::COORD_W-1:0]  m_point_y,
    output logic signed [drp_pkg::COORD_W-1:0]  m_point_z,
    output logic                                m_point_valid,
    output logic                                m_saturated,
    output logic                                m_frame_end,
    input  logic                                cfg_wr_en,
    input  logic [drp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [drp_pkg::BASE_W-1:0]          cfg_wdata
);
    logic [drp_pkg::BASE_W-1:0] baseline_reg;
    logic [drp_pkg::PARM_W-1:0] focal_reg, ccol_reg, crow_reg;
    logic [drp_pkg::SIZE_W-1:0] width_reg, height_reg;

    drp_pkg::item_t     f_item, q_head;
    drp_pkg::q_status_t q_status;
    logic               push, pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg <= drp_pkg::BASE_W'(491520);
            focal_reg    <= drp_pkg::PARM_W'(8000);
            ccol_reg     <= drp_pkg::PARM_W'(5120);
            crow_reg     <= drp_pkg::PARM_W'(3840);
            width_reg    <= drp_pkg::SIZE_W'(640);
            height_reg   <= drp_pkg::SIZE_W'(480);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                drp_pkg::REG_BASELINE:     baseline_reg <= cfg_wdata;
                drp_pkg::REG_FOCAL_LENGTH: focal_reg    <= cfg_wdata[drp_pkg::PARM_W-1:0];
                drp_pkg::REG_CENTER_COL:   ccol_reg     <= cfg_wdata[drp_pkg::PARM_W-1:0];
                drp_pkg::REG_CENTER_ROW:   crow_reg     <= cfg_wdata[drp_pkg::PARM_W-1:0];
                drp_pkg::REG_IMAGE_WIDTH:  width_reg    <= cfg_wdata[drp_pkg::SIZE_W-1:0];
                drp_pkg::REG_IMAGE_HEIGHT: height_reg   <= cfg_wdata[drp_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    drp_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_disparity  (s_disparity),
        .image_width  (width_reg),
        .image_height (height_reg),
        .center_col   (ccol_reg),
        .center_row   (crow_reg),
        .q_status     (q_status),
        .push         (push),
        .item         (f_item)
    );

    drp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_item (f_item),
        .pop     (pop),
        .rd_item (q_head),
        .status  (q_status)
    );

    drp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_status      (q_status),
        .head          (q_head),
        .pop           (pop),
        .baseline      (baseline_reg),
        .focal_length  (focal_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_x     (m_point_x),
        .m_point_y     (m_point_y),
        .m_point_z     (m_point_z),
        .m_point_valid (m_point_valid),
        .m_saturated   (m_saturated),
        .m_frame_end   (m_frame_end)
    );
endmodule
